// File: sv/ptuv_pkg.sv
// ptuv_pkg: shared types and constants of the projected triangle uv hit unit
// depends on nothing; imported by ptuv_div and projected_triangle_uv_hit_unit

package ptuv_pkg;

   // word width of every Q-format field
   localparam int VAL_W  = 32;
   // wide datapath: covers the largest numerator (three 68 x 32 bit products)
   localparam int AW     = 104;
   // shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 66;

   // item modes
   localparam logic MODE_MATRIX = 1'b0;
   localparam logic MODE_VERTEX = 1'b1;

   // matrix row codes
   localparam logic [1:0] ROW_X = 2'd0;
   localparam logic [1:0] ROW_Y = 2'd1;
   localparam logic [1:0] ROW_W = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_MISS    = 2'd0;
   localparam logic [1:0] STATUS_HIT     = 2'd1;
   localparam logic [1:0] STATUS_DEGEN   = 2'd2;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_QUERY_X = 2'd0;
   localparam logic [1:0] CSR_QUERY_Y = 2'd1;

   typedef struct packed {
      logic              mode;
      logic [1:0]        row;
      logic signed [31:0] value_a;
      logic signed [31:0] value_b;
      logic signed [31:0] value_c;
      logic signed [31:0] value_d;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_u;
      logic signed [31:0] out_v;
   } rsp_payload_type;

endpackage

// File: sv/ptuv_div.sv
// ptuv_div: signed restoring divider, one quotient bit per cycle, 32-bit saturated result
// depends on ptuv_pkg

module ptuv_div import ptuv_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] num,
   input  logic signed [AW-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic signed [VAL_W-1:0] quot
);

   localparam int CW = $clog2(AW + 1);

   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [AW-1:0]  un_ff, ud_ff, rem_ff;
   logic [VAL_W:0] q_ff;
   logic           ovf_ff, neg_ff, zero_ff;

   logic [AW-1:0] num_mag, den_mag;
   logic [AW:0]   rem_sh, rem_sub;
   logic          fits;
   logic          pos_big, neg_big;

   // operand magnitudes
   assign num_mag = num[AW-1] ? AW'(-num) : AW'(num);
   assign den_mag = den[AW-1] ? AW'(-den) : AW'(den);

   // one restoring step
   assign rem_sh  = {rem_ff, un_ff[AW-1]};
   assign fits    = rem_sh >= {1'b0, ud_ff};
   assign rem_sub = rem_sh - {1'b0, ud_ff};

   // iteration control
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(AW);
      end else if (run_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // magnitude datapath
   always_ff @(posedge clock) begin
      if (start) begin
         un_ff   <= num_mag;
         ud_ff   <= den_mag;
         rem_ff  <= '0;
         q_ff    <= '0;
         ovf_ff  <= 1'b0;
         neg_ff  <= num[AW-1] ^ den[AW-1];
         zero_ff <= (den == '0);
      end else if (run_ff) begin
         un_ff  <= un_ff << 1;
         rem_ff <= fits ? rem_sub[AW-1:0] : rem_sh[AW-1:0];
         q_ff   <= {q_ff[VAL_W-1:0], fits};
         ovf_ff <= ovf_ff | q_ff[VAL_W];
      end
   end

   // sign and saturation
   assign pos_big = ovf_ff | q_ff[VAL_W] | q_ff[VAL_W-1];
   assign neg_big = ovf_ff | q_ff[VAL_W] | (q_ff[VAL_W-1] & (|q_ff[VAL_W-2:0]));

   always_comb begin
      if (zero_ff)
         quot = '0;
      else if (neg_ff)
         quot = neg_big ? $signed({1'b1, {(VAL_W-1){1'b0}}}) : $signed(-q_ff[VAL_W-1:0]);
      else
         quot = pos_big ? $signed({1'b0, {(VAL_W-1){1'b1}}}) : $signed(q_ff[VAL_W-1:0]);
   end

   assign busy = run_ff;
   assign done = done_ff;

endmodule

// File: sv/projected_triangle_uv_hit_unit.sv
// a matrix row is written when it is taken; a vertex runs the projection multiply-accumulate steps
// then two divides (x, y), skipped when its w has magnitude below one; the third vertex of a triangle
// adds the area, weight and uv products and, unless degenerate or a miss, two more divides (u, v)
// one item at a time: the single 33x33 multiplier and the bit-serial divider set the pace
// synchronous active-high reset clears the sequencer, vertex count, query registers and output valid
// depends on ptuv_pkg and ptuv_div

module projected_triangle_uv_hit_unit import ptuv_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_index,
   input  logic [31:0]     csr_data
);

   localparam logic signed [VAL_W-1:0] ONE_Q = VAL_W'(1) << FRAC_BITS;
   localparam logic signed [MUL_W-1:0] ONE_M = MUL_W'(1) << FRAC_BITS;
   localparam logic signed [AW-1:0]    ONE_W = AW'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PROJ, ST_WCHK, ST_DIVX, ST_DIVY, ST_VERT, ST_TRI, ST_SIGN,
      ST_N2A, ST_N2B, ST_CMP, ST_UV, ST_DIVU, ST_DIVV, ST_STAT, ST_DONE
   } state_type;

   // control state
   state_type state_ff, state_in;
   logic       ph_ff, ph_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] term_ff, term_in;
   logic       vsel_ff, vsel_in;
   logic [1:0] vcount_ff, vcount_in;
   logic       bad_ff, bad_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0] query_x_ff, query_x_in;
   logic signed [VAL_W-1:0] query_y_ff, query_y_in;

   // datapath registers
   req_payload_type         item_ff;
   logic signed [VAL_W-1:0] mat_ff [12];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [AW-1:0]    acc_ff, sx_ff, sy_ff, sw_ff;
   logic signed [AW-1:0]    den_ff, n0_ff, n1_ff, n2_ff, lim_ff, nu_ff;
   logic                    w_ok_ff;
   logic signed [VAL_W-1:0] nx_ff, ny_ff, ou_ff, ov_ff;
   logic signed [VAL_W-1:0] proj_x_ff [2];
   logic signed [VAL_W-1:0] proj_y_ff [2];
   logic signed [VAL_W-1:0] held_u_ff [2];
   logic signed [VAL_W-1:0] held_v_ff [2];
   rsp_payload_type         res_ff, rsp_payload_ff;

   // combinational helpers
   logic                    req_xfer, mul_phase, div_state, rsp_load;
   logic signed [VAL_W-1:0] mat_rd;
   logic signed [MUL_W-1:0] d_y1y2, d_x0x2, d_x2x1, d_y0y2, d_y2y0, d_qx, d_qy;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic [1:0]              mul_sh, n_pick;
   logic                    mul_clr;
   logic signed [PROD_W-1:0] mul_p;
   logic signed [AW-1:0]    prod_ext, acc_add, acc_next, n_sel;
   logic signed [VAL_W-1:0] uv_sel;

   logic                    div_start, div_busy, div_done;
   logic signed [AW-1:0]    div_num, div_den;
   logic signed [VAL_W-1:0] div_quot;

   assign req_xfer  = req_valid && !req_stall;
   assign mul_phase = (state_ff == ST_PROJ) || (state_ff == ST_TRI) || (state_ff == ST_UV);
   assign div_state = (state_ff == ST_DIVX) || (state_ff == ST_DIVY) ||
                      (state_ff == ST_DIVU) || (state_ff == ST_DIVV);
   assign div_start = div_state && !ph_ff;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // coordinate differences for the area and weight numerators
   assign mat_rd = mat_ff[idx_ff];
   assign d_y1y2 = MUL_W'(proj_y_ff[1]) - MUL_W'(ny_ff);
   assign d_x0x2 = MUL_W'(proj_x_ff[0]) - MUL_W'(nx_ff);
   assign d_x2x1 = MUL_W'(nx_ff) - MUL_W'(proj_x_ff[1]);
   assign d_y0y2 = MUL_W'(proj_y_ff[0]) - MUL_W'(ny_ff);
   assign d_y2y0 = MUL_W'(ny_ff) - MUL_W'(proj_y_ff[0]);
   assign d_qx   = MUL_W'(query_x_ff) - MUL_W'(nx_ff);
   assign d_qy   = MUL_W'(query_y_ff) - MUL_W'(ny_ff);

   // weight numerator select
   assign n_pick = (state_ff == ST_CMP) ? idx_ff[1:0] : term_ff;
   always_comb begin
      case (n_pick)
         2'd0:    n_sel = n0_ff;
         2'd1:    n_sel = n1_ff;
         default: n_sel = n2_ff;
      endcase
   end

   // texture coordinate select
   always_comb begin
      case (term_ff)
         2'd0:    uv_sel = vsel_ff ? held_v_ff[0] : held_u_ff[0];
         2'd1:    uv_sel = vsel_ff ? held_v_ff[1] : held_u_ff[1];
         default: uv_sel = vsel_ff ? item_ff.tex_v : item_ff.tex_u;
      endcase
   end

   // shared multiplier operand select
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_sh  = 2'd0;
      mul_clr = 1'b0;
      unique case (state_ff)
         ST_PROJ: begin
            mul_a   = MUL_W'(mat_rd);
            mul_clr = (idx_ff[1:0] == 2'd0);
            case (idx_ff[1:0])
               2'd0:    mul_b = MUL_W'(item_ff.value_a);
               2'd1:    mul_b = MUL_W'(item_ff.value_b);
               2'd2:    mul_b = MUL_W'(item_ff.value_c);
               default: mul_b = ONE_M;
            endcase
         end
         ST_TRI: begin
            case (idx_ff[2:0])
               3'd0: begin
                  mul_a   = d_y1y2;
                  mul_b   = d_x0x2;
                  mul_clr = 1'b1;
               end
               3'd1: begin
                  mul_a = d_x2x1;
                  mul_b = d_y0y2;
               end
               3'd2: begin
                  mul_a   = d_y1y2;
                  mul_b   = d_qx;
                  mul_clr = 1'b1;
               end
               3'd3: begin
                  mul_a = d_x2x1;
                  mul_b = d_qy;
               end
               3'd4: begin
                  mul_a   = d_y2y0;
                  mul_b   = d_qx;
                  mul_clr = 1'b1;
               end
               default: begin
                  mul_a = d_x0x2;
                  mul_b = d_qy;
               end
            endcase
         end
         ST_UV: begin
            mul_b   = MUL_W'(uv_sel);
            mul_sh  = idx_ff[1:0];
            mul_clr = (term_ff == 2'd0) && (idx_ff[1:0] == 2'd0);
            case (idx_ff[1:0])
               2'd0:    mul_a = $signed({1'b0, n_sel[31:0]});
               2'd1:    mul_a = $signed({1'b0, n_sel[63:32]});
               default: mul_a = $signed(n_sel[96:64]);
            endcase
         end
         default: ;
      endcase
   end

   // product and accumulate
   assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_ext = AW'(prod_ff);
   always_comb begin
      case (mul_sh)
         2'd0:    acc_add = prod_ext;
         2'd1:    acc_add = prod_ext <<< 32;
         default: acc_add = prod_ext <<< 64;
      endcase
   end
   assign acc_next = (mul_clr ? AW'(0) : acc_ff) + acc_add;

   // divider operand select
   always_comb begin
      unique case (state_ff)
         ST_DIVX: begin
            div_num = sx_ff <<< FRAC_BITS;
            div_den = sw_ff;
         end
         ST_DIVY: begin
            div_num = sy_ff <<< FRAC_BITS;
            div_den = sw_ff;
         end
         ST_DIVU: begin
            div_num = nu_ff;
            div_den = den_ff;
         end
         default: begin
            div_num = acc_ff;
            div_den = den_ff;
         end
      endcase
   end

   ptuv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      term_in      = term_ff;
      vsel_in      = vsel_ff;
      vcount_in    = vcount_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      query_x_in   = query_x_ff;
      query_y_in   = query_y_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_QUERY_X: query_x_in = $signed(csr_data);
            CSR_QUERY_Y: query_y_in = $signed(csr_data);
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && req_payload.mode == MODE_VERTEX) begin
               state_in = ST_PROJ;
               ph_in    = 1'b0;
               idx_in   = 4'd0;
            end
         end
         ST_PROJ: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd11)
                  state_in = ST_WCHK;
            end
         end
         ST_WCHK: begin
            ph_in = 1'b0;
            if (!(sw_ff > -ONE_W && sw_ff < ONE_W))
               state_in = ST_DIVX;
            else
               state_in = ST_VERT;
         end
         ST_DIVX, ST_DIVY, ST_DIVU, ST_DIVV: begin
            if (!ph_ff) begin
               ph_in = 1'b1;
            end else if (div_done) begin
               ph_in = 1'b0;
               unique case (state_ff)
                  ST_DIVX: state_in = ST_DIVY;
                  ST_DIVY: state_in = ST_VERT;
                  ST_DIVU: state_in = ST_DIVV;
                  default: state_in = ST_STAT;
               endcase
            end
         end
         ST_VERT: begin
            if (vcount_ff < 2'd2) begin
               vcount_in = vcount_ff + 2'd1;
               bad_in    = bad_ff || !w_ok_ff;
               state_in  = ST_IDLE;
            end else if (bad_ff || !w_ok_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_TRI;
               ph_in    = 1'b0;
               idx_in   = 4'd0;
            end
         end
         ST_TRI: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd5)
                  state_in = ST_SIGN;
            end
         end
         ST_SIGN: begin
            state_in = (den_ff == '0) ? ST_DONE : ST_N2A;
         end
         ST_N2A: state_in = ST_N2B;
         ST_N2B: begin
            state_in = ST_CMP;
            idx_in   = 4'd0;
         end
         ST_CMP: begin
            if ((n_sel <<< FRAC_BITS) < lim_ff) begin
               state_in = ST_DONE;
            end else if (idx_ff == 4'd2) begin
               state_in = ST_UV;
               idx_in   = 4'd0;
               term_in  = 2'd0;
               vsel_in  = 1'b0;
               ph_in    = 1'b0;
            end else begin
               idx_in = idx_ff + 4'd1;
            end
         end
         ST_UV: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (idx_ff[1:0] == 2'd2) begin
                  idx_in = 4'd0;
                  if (term_ff == 2'd2) begin
                     term_in = 2'd0;
                     if (vsel_ff)
                        state_in = ST_DIVU;
                     else
                        vsel_in = 1'b1;
                  end else begin
                     term_in = term_ff + 2'd1;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end
         ST_STAT: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               vcount_in    = 2'd0;
               bad_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         idx_ff       <= 4'd0;
         term_ff      <= 2'd0;
         vsel_ff      <= 1'b0;
         vcount_ff    <= 2'd0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         query_x_ff   <= '0;
         query_y_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         idx_ff       <= idx_in;
         term_ff      <= term_in;
         vsel_ff      <= vsel_in;
         vcount_ff    <= vcount_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         query_x_ff   <= query_x_in;
         query_y_ff   <= query_y_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      // matrix row load and vertex capture
      if (req_xfer) begin
         item_ff <= req_payload;
         if (req_payload.mode == MODE_MATRIX && req_payload.row != 2'd3) begin
            mat_ff[{req_payload.row, 2'd0}] <= req_payload.value_a;
            mat_ff[{req_payload.row, 2'd1}] <= req_payload.value_b;
            mat_ff[{req_payload.row, 2'd2}] <= req_payload.value_c;
            mat_ff[{req_payload.row, 2'd3}] <= req_payload.value_d;
         end
      end

      // multiply then accumulate
      if (mul_phase && !ph_ff)
         prod_ff <= mul_p;
      if (mul_phase && ph_ff)
         acc_ff <= acc_next;

      // clip coordinates
      if (state_ff == ST_PROJ && ph_ff && idx_ff[1:0] == 2'd3) begin
         case (idx_ff[3:2])
            ROW_X:   sx_ff <= acc_next;
            ROW_Y:   sy_ff <= acc_next;
            default: sw_ff <= acc_next;
         endcase
      end

      // w check (magnitude below one fails), projected coordinates
      if (state_ff == ST_WCHK) begin
         w_ok_ff <= !(sw_ff > -ONE_W && sw_ff < ONE_W);
         nx_ff   <= '0;
         ny_ff   <= '0;
      end
      if (state_ff == ST_DIVX && ph_ff && div_done)
         nx_ff <= div_quot;
      if (state_ff == ST_DIVY && ph_ff && div_done)
         ny_ff <= div_quot;

      // hold a vertex or flag a degenerate triangle
      if (state_ff == ST_VERT) begin
         if (vcount_ff < 2'd2) begin
            proj_x_ff[vcount_ff[0]] <= nx_ff;
            proj_y_ff[vcount_ff[0]] <= ny_ff;
            held_u_ff[vcount_ff[0]] <= item_ff.tex_u;
            held_v_ff[vcount_ff[0]] <= item_ff.tex_v;
         end else if (bad_ff || !w_ok_ff) begin
            res_ff <= '{status: STATUS_DEGEN, out_u: '0, out_v: '0};
         end
      end

      // area and weight numerators
      if (state_ff == ST_TRI && ph_ff) begin
         case (idx_ff[2:0])
            3'd1:    den_ff <= acc_next;
            3'd3:    n0_ff  <= acc_next;
            3'd5:    n1_ff  <= acc_next;
            default: ;
         endcase
      end

      // orientation fix, or flag a zero-area triangle
      if (state_ff == ST_SIGN) begin
         if (den_ff == '0) begin
            res_ff <= '{status: STATUS_DEGEN, out_u: '0, out_v: '0};
         end else if (den_ff < 0) begin
            den_ff <= -den_ff;
            n0_ff  <= -n0_ff;
            n1_ff  <= -n1_ff;
         end
      end
      if (state_ff == ST_N2A)
         n2_ff <= den_ff - n0_ff;
      if (state_ff == ST_N2B) begin
         n2_ff  <= n2_ff - n1_ff;
         lim_ff <= -den_ff;
      end

      // inside test, one weight a cycle
      if (state_ff == ST_CMP && (n_sel <<< FRAC_BITS) < lim_ff)
         res_ff <= '{status: STATUS_MISS, out_u: '0, out_v: '0};

      // interpolation numerators and quotients
      if (state_ff == ST_UV && ph_ff && !vsel_ff && term_ff == 2'd2 && idx_ff[1:0] == 2'd2)
         nu_ff <= acc_next;
      if (state_ff == ST_DIVU && ph_ff && div_done)
         ou_ff <= div_quot;
      if (state_ff == ST_DIVV && ph_ff && div_done)
         ov_ff <= div_quot;

      // hit classification
      if (state_ff == ST_STAT) begin
         res_ff.out_u <= ou_ff;
         res_ff.out_v <= ov_ff;
         if (ou_ff < 0 || ou_ff > ONE_Q || ov_ff < 0 || ov_ff > ONE_Q)
            res_ff.status <= STATUS_OUTSIDE;
         else
            res_ff.status <= STATUS_HIT;
      end

      // output register
      if (rsp_load)
         rsp_payload_ff <= res_ff;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready   = 1'b1;

   // checks
   a_vcount_range: assert property (@(posedge clock) disable iff (reset)
      vcount_ff != 2'd3)
      else $error("vertex count out of range");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while running");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (div_state && ph_ff))
      else $error("divider finished outside a divide step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result shown without a finished triangle");

   a_vertex_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_payload.mode == MODE_VERTEX) |=> req_stall)
      else $error("vertex transfer did not start the sequencer");

endmodule
